// ===== hw/rtl/slipdec_pkg.sv =====
// slipdec_pkg: shared types and byte codes for the slip frame decoder
// no dependencies; used by the interfaces, the decoder modules and the checker
package slipdec_pkg;

  // slip special bytes
  localparam logic [7:0] BYTE_END     = 8'hC0;
  localparam logic [7:0] BYTE_ESC     = 8'hDB;
  localparam logic [7:0] BYTE_ESC_END = 8'hDC;
  localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

  // input word commands
  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // reset value of the buffer size register
  localparam logic [7:0] BUFFER_SIZE_RESET = 8'd255;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       frame_done;
    logic [7:0] frame_length;
  } out_item_t;

endpackage

// ===== hw/rtl/slipdec_in_if.sv =====
// slipdec_in_if: valid/ready channel carrying one input word
// depends on slipdec_pkg for the payload type
interface slipdec_in_if
  import slipdec_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/slipdec_out_if.sv =====
// slipdec_out_if: valid/ready channel carrying one result word
// depends on slipdec_pkg for the payload type
interface slipdec_out_if
  import slipdec_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/slip_frame_decoder.sv =====
// slip_frame_decoder: slip byte stream decoder, one input word in, one result word out
// a result word goes to the output register, or to the skid entry while the result
// side stalls; throughput: one word per cycle while the skid entry is empty, so input
// keeps flowing for one more word while the result side stalls
// reset (rst_n low, synchronous): waits for an end byte, index 0, buffer size 255,
// output and skid entries empty
module slip_frame_decoder
  import slipdec_pkg::*;
#(
  parameter int INDEX_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  slipdec_in_if.sink    in_ch,
  slipdec_out_if.source out_ch,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0] buffer_size_r;
  logic       in_accept;
  out_item_t  result;

  // buffer size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= BUFFER_SIZE_RESET;
    end else if (cfg_wr_en) begin
      buffer_size_r <= cfg_wr_data;
    end
  end

  assign in_accept = in_ch.valid && in_ch.ready;

  slipdec_core #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .item        (in_ch.data),
    .buffer_size (buffer_size_r),
    .result      (result)
  );

  slipdec_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_data  (result),
    .push_ready (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_data   (out_ch.data),
    .out_ready  (out_ch.ready)
  );

endmodule

// ===== hw/rtl/slipdec_core.sv =====
// slipdec_core: slip decode state machine and write index counter
// depends on slipdec_pkg; produces one result word per accepted input word
module slipdec_core
  import slipdec_pkg::*;
#(
  parameter int INDEX_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  in_item_t   item,
  input  logic [7:0] buffer_size,
  output out_item_t  result
);

  // index compare width covers both the index and the 8-bit size register
  localparam int CMP_W = (INDEX_WIDTH > 8) ? INDEX_WIDTH : 8;

  typedef enum logic [1:0] {
    MODE_WAIT   = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_ESCAPE = 2'd2
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [INDEX_WIDTH-1:0] idx_r, idx_nxt;

  logic                   do_store;
  logic                   closed;
  logic [7:0]             store_byte;
  logic [INDEX_WIDTH-1:0] idx_step;
  logic [CMP_W-1:0]       idx_cur_ext;
  logic [CMP_W-1:0]       idx_step_ext;
  logic [CMP_W-1:0]       size_ext;

  assign idx_cur_ext  = CMP_W'(idx_r);
  assign size_ext     = CMP_W'(buffer_size);
  assign idx_step     = do_store ? (idx_r + INDEX_WIDTH'(1)) : idx_r;
  assign idx_step_ext = CMP_W'(idx_step);

  // decode one word
  always_comb begin
    mode_nxt   = mode_r;
    do_store   = 1'b0;
    closed     = 1'b0;
    store_byte = item.data_byte;
    result     = '0;

    if (item.command == CMD_RESTART) begin
      mode_nxt = MODE_WAIT;
      closed   = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_ESCAPE: begin
          mode_nxt = MODE_STORE;
          do_store = 1'b1;
          if (item.data_byte == BYTE_ESC_END) begin
            store_byte = BYTE_END;
          end else if (item.data_byte == BYTE_ESC_ESC) begin
            store_byte = BYTE_ESC;
          end
        end
        MODE_STORE: begin
          if (item.data_byte == BYTE_ESC) begin
            mode_nxt = MODE_ESCAPE;
          end else if (item.data_byte == BYTE_END) begin
            // end on an empty frame is dropped
            if (idx_r != '0) begin
              mode_nxt            = MODE_WAIT;
              closed              = 1'b1;
              result.frame_done   = 1'b1;
              result.frame_length = idx_cur_ext[7:0];
            end
          end else begin
            do_store = 1'b1;
          end
        end
        default: begin
          mode_nxt = (item.data_byte == BYTE_END) ? MODE_STORE : MODE_WAIT;
        end
      endcase
    end

    if (do_store) begin
      result.store_valid = 1'b1;
      result.store_index = idx_cur_ext[7:0];
      result.store_byte  = store_byte;
    end

    // next index: restart clears, buffer full wraps, frame close keeps it
    if (item.command == CMD_RESTART) begin
      idx_nxt = '0;
    end else if (!closed && (idx_step_ext == size_ext)) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = idx_step;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WAIT;
      idx_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

// ===== hw/rtl/slipdec_outbuf.sv =====
// slipdec_outbuf: result register with one skid entry
// depends on slipdec_pkg for the result word type
module slipdec_outbuf
  import slipdec_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      push_ready,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_ready
);

  logic      out_valid_r;
  logic      skid_valid_r;
  out_item_t out_data_r;
  out_item_t skid_data_r;
  logic      out_free;

  // output slot can load when empty or being taken this cycle
  assign out_free   = !out_valid_r || out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

// ===== hw/rtl/slipdec_checker.sv =====
// slipdec_checker: port-level assertions for slip_frame_decoder, bound to the top level
// depends on slipdec_pkg for the result word type
module slipdec_checker
  import slipdec_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result word holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // a word never both stores a byte and closes a frame
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.store_valid && out_data.frame_done))
    else $error("store and frame close in one word");

  // store fields are zero without a store
  a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.store_valid |->
      out_data.store_index == 8'd0 && out_data.store_byte == 8'd0)
    else $error("store fields set without store_valid");

  // frame length is zero without a frame close
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_done |-> out_data.frame_length == 8'd0)
    else $error("frame_length set without frame_done");

endmodule

bind slip_frame_decoder slipdec_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
